// ----- src/assert_macros.svh -----
// Assertion helpers used by the checker in isim_chk.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define CHK_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/isim_pkg.sv -----
package isim_pkg;

    localparam int POS_W  = 24;
    localparam int STAT_W = 3;
    localparam int TOT_W  = 7;

    typedef enum logic [STAT_W-1:0] {
        ST_COVERED   = 3'd0,
        ST_GREW_PREV = 3'd1,
        ST_GREW_NEXT = 3'd2,
        ST_JOINED    = 3'd3,
        ST_NEW       = 3'd4,
        ST_FULL      = 3'd5,
        ST_CLEARED   = 3'd6
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_INS_WR,
        S_DONE
    } t_state;

    typedef struct packed {
        t_status          status;
        logic [TOT_W-1:0] total;
        logic [POS_W-1:0] cov_first;
        logic [POS_W-1:0] cov_last;
    } t_result;

endpackage

// ----- src/interval_set_insert_merge_core.sv -----
// Channel | Handshake                 | Payload
// --------+---------------------------+-----------------------------------------------
// request | i_req_valid / o_req_ready | i_req_type, i_position
// result  | o_res_valid / i_res_ready | o_status, o_range_total, o_covering_start/_end
//
// Clear goes from accept straight to its result. Insert scans the table, reading one
// entry per range whose first position is at or below the request position, plus
// one for the first range above it if there is one, then decides; it moves ranges
// with a read and a write each when a range is added or two join, and writes a new one.
// One request is in work at a time; the next is taken once its result is registered.
// Synchronous active-low reset empties the table; table contents are kept as is.
// A stalled result holds in the output register while the next request is worked on.
module interval_set_insert_merge_core import isim_pkg::*; #(
    parameter int MAX_RANGES = 64,
    parameter int POS_BITS   = 24
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    output logic              o_req_ready,
    input  logic              i_req_type,
    input  logic [POS_W-1:0]  i_position,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output logic [STAT_W-1:0] o_status,
    output logic [TOT_W-1:0]  o_range_total,
    output logic [POS_W-1:0]  o_covering_start,
    output logic [POS_W-1:0]  o_covering_end
);

    localparam int AW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam int CW = $clog2(MAX_RANGES + 1);
    localparam int XW = (POS_BITS > POS_W) ? POS_BITS : POS_W;

    logic [XW-1:0]         w_pos_ext;
    logic [POS_BITS-1:0]   w_pos;
    logic [AW-1:0]         w_rd_addr;
    logic [2*POS_BITS-1:0] w_rd_data;
    logic                  w_wr_en;
    logic [AW-1:0]         w_wr_addr;
    logic [2*POS_BITS-1:0] w_wr_data;
    logic                  w_res_valid;
    logic                  w_res_free;
    t_result               w_res;
    logic                  r_out_valid;
    t_result               r_out;

    assign w_pos_ext  = XW'(i_position);
    assign w_pos      = w_pos_ext[POS_BITS-1:0];
    assign w_res_free = !r_out_valid || i_res_ready;

    isim_ctrl #(
        .MAX_RANGES (MAX_RANGES),
        .POS_BITS   (POS_BITS),
        .AW         (AW),
        .CW         (CW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req_type  (i_req_type),
        .i_pos       (w_pos),
        .o_rd_addr   (w_rd_addr),
        .i_rd_data   (w_rd_data),
        .o_wr_en     (w_wr_en),
        .o_wr_addr   (w_wr_addr),
        .o_wr_data   (w_wr_data),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_free),
        .o_res       (w_res)
    );

    isim_ram #(
        .DEPTH (MAX_RANGES),
        .AW    (AW),
        .DW    (2 * POS_BITS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid && w_res_free) begin
            r_out_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid && w_res_free) begin
            r_out <= w_res;
        end
    end

    assign o_res_valid      = r_out_valid;
    assign o_status         = r_out.status;
    assign o_range_total    = r_out.total;
    assign o_covering_start = r_out.cov_first;
    assign o_covering_end   = r_out.cov_last;

endmodule

// ----- src/isim_ram.sv -----
module isim_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int DW    = 48
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [DW-1:0] i_wr_data,
    input  logic [AW-1:0] i_rd_addr,
    output logic [DW-1:0] o_rd_data
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- src/isim_ctrl.sv -----
module isim_ctrl import isim_pkg::*; #(
    parameter int MAX_RANGES = 64,
    parameter int POS_BITS   = 24,
    parameter int AW         = 6,
    parameter int CW         = 7
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_req_valid,
    output logic                  o_req_ready,
    input  logic                  i_req_type,
    input  logic [POS_BITS-1:0]   i_pos,
    output logic [AW-1:0]         o_rd_addr,
    input  logic [2*POS_BITS-1:0] i_rd_data,
    output logic                  o_wr_en,
    output logic [AW-1:0]         o_wr_addr,
    output logic [2*POS_BITS-1:0] o_wr_data,
    output logic                  o_res_valid,
    input  logic                  i_res_ready,
    output t_result               o_res
);

    localparam int XW  = (POS_BITS > POS_W) ? POS_BITS : POS_W;
    localparam int TXW = (CW > TOT_W) ? CW : TOT_W;

    function automatic logic [POS_W-1:0] f_pos_out(input logic [POS_BITS-1:0] v);
        logic [XW-1:0] w;
        w = XW'(v);
        return w[POS_W-1:0];
    endfunction

    function automatic logic [TOT_W-1:0] f_tot_out(input logic [CW-1:0] v);
        logic [TXW-1:0] w;
        w = TXW'(v);
        return w[TOT_W-1:0];
    endfunction

    t_state              r_state, n_state;
    logic [CW-1:0]       r_used, n_used;
    logic [POS_BITS-1:0] r_pos, n_pos;
    logic [CW-1:0]       r_ptr, n_ptr;
    logic [CW-1:0]       r_idx, n_idx;
    logic [CW-1:0]       r_src, n_src;
    logic                r_del, n_del;
    logic                r_has_prev, n_has_prev;
    logic                r_has_next, n_has_next;
    logic [POS_BITS-1:0] r_prev_first, n_prev_first;
    logic [POS_BITS-1:0] r_prev_last, n_prev_last;
    logic [POS_BITS-1:0] r_next_first, n_next_first;
    logic [POS_BITS-1:0] r_next_last, n_next_last;
    t_result             r_res, n_res;

    logic [POS_BITS-1:0] w_rd_first;
    logic [POS_BITS-1:0] w_rd_last;
    logic                w_le;
    logic [CW-1:0]       w_ptr_inc;
    logic [CW-1:0]       w_idx_inc;
    logic [CW-1:0]       w_idx_dec;
    logic [CW-1:0]       w_src_inc;
    logic [CW-1:0]       w_src_dec;
    logic [POS_BITS:0]   w_prev_inc;
    logic [POS_BITS:0]   w_pos_inc;
    logic                w_cov;
    logic                w_gp;
    logic                w_gn;
    logic                w_full;

    assign w_rd_first = i_rd_data[2*POS_BITS-1:POS_BITS];
    assign w_rd_last  = i_rd_data[POS_BITS-1:0];
    assign w_le       = (w_rd_first <= r_pos);
    assign w_ptr_inc  = r_ptr + CW'(1);
    assign w_idx_inc  = r_idx + CW'(1);
    assign w_idx_dec  = r_idx - CW'(1);
    assign w_src_inc  = r_src + CW'(1);
    assign w_src_dec  = r_src - CW'(1);
    assign w_prev_inc = {1'b0, r_prev_last} + (POS_BITS+1)'(1);
    assign w_pos_inc  = {1'b0, r_pos} + (POS_BITS+1)'(1);
    assign w_cov      = r_has_prev && (r_pos <= r_prev_last);
    assign w_gp       = r_has_prev && (w_prev_inc == {1'b0, r_pos});
    assign w_gn       = r_has_next && (r_pos != {POS_BITS{1'b1}})
                        && ({1'b0, r_next_first} == w_pos_inc);
    assign w_full     = (r_used >= CW'(MAX_RANGES));

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    if (i_req_type) begin
                        n_state = S_DONE;
                    end else if (r_used == '0) begin
                        n_state = S_DECIDE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (!w_le || (w_ptr_inc >= r_used)) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (w_cov) begin
                    n_state = S_DONE;
                end else if (w_gp && w_gn) begin
                    n_state = (w_idx_inc < r_used) ? S_SHIFT_RD : S_DONE;
                end else if (w_gp || w_gn || w_full) begin
                    n_state = S_DONE;
                end else begin
                    n_state = (r_used > r_idx) ? S_SHIFT_RD : S_INS_WR;
                end
            end
            S_SHIFT_RD: begin
                n_state = S_SHIFT_WR;
            end
            S_SHIFT_WR: begin
                if (r_del) begin
                    n_state = (r_src >= r_used) ? S_DONE : S_SHIFT_RD;
                end else begin
                    n_state = (r_src == r_idx) ? S_INS_WR : S_SHIFT_RD;
                end
            end
            S_INS_WR: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_req_ready  = 1'b0;
        o_res_valid  = 1'b0;
        o_rd_addr    = r_ptr[AW-1:0];
        o_wr_en      = 1'b0;
        o_wr_addr    = r_idx[AW-1:0];
        o_wr_data    = {r_pos, r_pos};
        n_used       = r_used;
        n_pos        = r_pos;
        n_ptr        = r_ptr;
        n_idx        = r_idx;
        n_src        = r_src;
        n_del        = r_del;
        n_has_prev   = r_has_prev;
        n_has_next   = r_has_next;
        n_prev_first = r_prev_first;
        n_prev_last  = r_prev_last;
        n_next_first = r_next_first;
        n_next_last  = r_next_last;
        n_res        = r_res;
        case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                o_rd_addr   = '0;
                if (i_req_valid) begin
                    n_pos      = i_pos;
                    n_ptr      = '0;
                    n_idx      = '0;
                    n_has_prev = 1'b0;
                    n_has_next = 1'b0;
                    if (i_req_type) begin
                        n_used = '0;
                        n_res  = '{status: ST_CLEARED, total: '0, cov_first: '0,
                                   cov_last: '0};
                    end
                end
            end
            S_SCAN: begin
                o_rd_addr = w_ptr_inc[AW-1:0];
                if (w_le) begin
                    n_has_prev   = 1'b1;
                    n_prev_first = w_rd_first;
                    n_prev_last  = w_rd_last;
                    n_ptr        = w_ptr_inc;
                    n_idx        = w_ptr_inc;
                end else begin
                    n_has_next   = 1'b1;
                    n_next_first = w_rd_first;
                    n_next_last  = w_rd_last;
                    n_idx        = r_ptr;
                end
            end
            S_DECIDE: begin
                if (w_cov) begin
                    n_res = '{status: ST_COVERED, total: f_tot_out(r_used),
                              cov_first: f_pos_out(r_prev_first),
                              cov_last: f_pos_out(r_prev_last)};
                end else if (w_gp && w_gn) begin
                    o_wr_en   = 1'b1;
                    o_wr_addr = w_idx_dec[AW-1:0];
                    o_wr_data = {r_prev_first, r_next_last};
                    n_used    = r_used - CW'(1);
                    n_src     = w_idx_inc;
                    n_del     = 1'b1;
                    n_res     = '{status: ST_JOINED, total: f_tot_out(r_used - CW'(1)),
                                  cov_first: f_pos_out(r_prev_first),
                                  cov_last: f_pos_out(r_next_last)};
                end else if (w_gp) begin
                    o_wr_en   = 1'b1;
                    o_wr_addr = w_idx_dec[AW-1:0];
                    o_wr_data = {r_prev_first, r_pos};
                    n_res     = '{status: ST_GREW_PREV, total: f_tot_out(r_used),
                                  cov_first: f_pos_out(r_prev_first),
                                  cov_last: f_pos_out(r_pos)};
                end else if (w_gn) begin
                    o_wr_en   = 1'b1;
                    o_wr_addr = r_idx[AW-1:0];
                    o_wr_data = {r_pos, r_next_last};
                    n_res     = '{status: ST_GREW_NEXT, total: f_tot_out(r_used),
                                  cov_first: f_pos_out(r_pos),
                                  cov_last: f_pos_out(r_next_last)};
                end else if (w_full) begin
                    n_res = '{status: ST_FULL, total: f_tot_out(r_used), cov_first: '0,
                              cov_last: '0};
                end else begin
                    n_used = r_used + CW'(1);
                    n_src  = r_used - CW'(1);
                    n_del  = 1'b0;
                    n_res  = '{status: ST_NEW, total: f_tot_out(r_used + CW'(1)),
                               cov_first: f_pos_out(r_pos), cov_last: f_pos_out(r_pos)};
                end
            end
            S_SHIFT_RD: begin
                o_rd_addr = r_src[AW-1:0];
            end
            S_SHIFT_WR: begin
                o_wr_en   = 1'b1;
                o_wr_data = i_rd_data;
                if (r_del) begin
                    o_wr_addr = w_src_dec[AW-1:0];
                    n_src     = w_src_inc;
                end else begin
                    o_wr_addr = w_src_inc[AW-1:0];
                    n_src     = w_src_dec;
                end
            end
            S_INS_WR: begin
                o_wr_en   = 1'b1;
                o_wr_addr = r_idx[AW-1:0];
                o_wr_data = {r_pos, r_pos};
            end
            S_DONE: begin
                o_res_valid = 1'b1;
            end
            default: begin
                o_req_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used  <= '0;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos        <= n_pos;
        r_ptr        <= n_ptr;
        r_idx        <= n_idx;
        r_src        <= n_src;
        r_del        <= n_del;
        r_has_prev   <= n_has_prev;
        r_has_next   <= n_has_next;
        r_prev_first <= n_prev_first;
        r_prev_last  <= n_prev_last;
        r_next_first <= n_next_first;
        r_next_last  <= n_next_last;
        r_res        <= n_res;
    end

    assign o_res = r_res;

endmodule

// ----- src/isim_chk.sv -----
`include "assert_macros.svh"

module isim_chk import isim_pkg::*; #(
    parameter int MAX_RANGES = 64
) (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_req_valid,
    input logic              o_req_ready,
    input logic              i_req_type,
    input logic [POS_W-1:0]  i_position,
    input logic              o_res_valid,
    input logic              i_res_ready,
    input logic [STAT_W-1:0] o_status,
    input logic [TOT_W-1:0]  o_range_total,
    input logic [POS_W-1:0]  o_covering_start,
    input logic [POS_W-1:0]  o_covering_end
);

    `CHK_NEXT(a_req_hold, i_clk, i_rst_n,
              i_req_valid && !o_req_ready,
              i_req_valid && $stable(i_req_type) && $stable(i_position),
              "waiting request changed")
    `CHK_NEXT(a_res_hold, i_clk, i_rst_n,
              o_res_valid && !i_res_ready,
              o_res_valid && $stable(o_status) && $stable(o_range_total)
              && $stable(o_covering_start) && $stable(o_covering_end),
              "stalled result changed")
    `CHK_ALWAYS(a_clear_zero, i_clk, i_rst_n,
                (o_res_valid && o_status == ST_CLEARED) |-> (o_range_total == '0
                && o_covering_start == '0 && o_covering_end == '0),
                "clear result not empty")
    `CHK_ALWAYS(a_full_count, i_clk, i_rst_n,
                (o_res_valid && o_status == ST_FULL) |-> (o_range_total == TOT_W'(MAX_RANGES)
                && o_covering_start == '0 && o_covering_end == '0),
                "full result with wrong count or range")
    `CHK_ALWAYS(a_range_order, i_clk, i_rst_n,
                o_res_valid |-> (o_covering_start <= o_covering_end),
                "covering range reversed")

endmodule

bind interval_set_insert_merge_core isim_chk #(.MAX_RANGES(MAX_RANGES)) u_isim_chk (.*);
